/* rtl/ps2_scancode_to_key_decoder_unit_defines.svh */
// assertion macros shared by the checker of the ps2 scan code decoder
// no dependencies; included by files that carry concurrent assertions
`ifndef PS2_SCANCODE_TO_KEY_DECODER_UNIT_DEFINES_SVH
`define PS2_SCANCODE_TO_KEY_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PS2KD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ps2kd assertion failed");

// next-cycle implication, disabled while in reset
`define PS2KD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ps2kd assertion failed");

`endif

/* rtl/ps2kd_pkg.sv */
// types, codes and lookup tables of the ps2 scan code decoder
// no dependencies; imported by the top level and by the checker
package ps2kd_pkg;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_REBOOT = 2'd2
    } kind_t;

    typedef enum logic {
        CFG_SCAN_SET = 1'b0,
        CFG_RAW_MODE = 1'b1
    } cfg_index_t;

    localparam logic [7:0] BYTE_EXT0   = 8'hE0;
    localparam logic [7:0] BYTE_EXT1   = 8'hE1;
    localparam logic [7:0] BYTE_BREAK  = 8'hF0;
    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_BAT    = 8'hFC;
    localparam logic [7:0] BYTE_DIAG   = 8'hFD;
    localparam logic [7:0] BYTE_RESEND = 8'hFE;
    localparam logic [7:0] CMD_SET_LEDS = 8'hED;
    localparam logic [7:0] XT_MAX      = 8'h58;
    localparam logic [7:0] XT_NONE     = 8'hFF;
    localparam logic [7:0] ACK_SAT     = 8'd253;
    localparam logic [1:0] SCAN_SET_XT = 2'd1;
    localparam logic [1:0] SCAN_SET_RESET = 2'd2;

    localparam logic [14:0] KC_UNKNOWN = 15'h4012;
    localparam logic [14:0] KC_LCTRL   = 15'h4003;
    localparam logic [14:0] KC_RCTRL   = 15'h4007;
    localparam logic [14:0] KC_LSHIFT  = 15'h4002;
    localparam logic [14:0] KC_RSHIFT  = 15'h4006;
    localparam logic [14:0] KC_LALT    = 15'h4004;
    localparam logic [14:0] KC_RALT    = 15'h4008;
    localparam logic [14:0] KC_CAPS    = 15'h4001;
    localparam logic [14:0] KC_NUMLOCK = 15'h300F;
    localparam logic [14:0] KC_SCROLL  = 15'h4010;
    localparam logic [14:0] KC_DOT     = 15'h002E;
    localparam logic [14:0] KC_LOWER_A = 15'h0061;
    localparam logic [14:0] KC_LOWER_Z = 15'h007A;
    localparam logic [14:0] CASE_GAP   = 15'h0020;

    localparam logic [2:0] LED_SCROLL = 3'b001;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_CAPS   = 3'b100;

    // result item held in the output queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] value;
        logic        last;
        logic [3:0]  flags;
    } res_t;

    localparam logic [14:0] XT_KEYS [0:88] = '{
        15'h4012, 15'h1001, 15'h0031, 15'h0032, 15'h0033, 15'h0034, 15'h0035, 15'h0036,
        15'h0037, 15'h0038, 15'h0039, 15'h0030, 15'h002D, 15'h003D, 15'h0008, 15'h4000,
        15'h0071, 15'h0077, 15'h0065, 15'h0072, 15'h0074, 15'h0079, 15'h0075, 15'h0069,
        15'h006F, 15'h0070, 15'h005B, 15'h005D, 15'h000D, 15'h4003, 15'h0061, 15'h0073,
        15'h0064, 15'h0066, 15'h0067, 15'h0068, 15'h006A, 15'h006B, 15'h006C, 15'h003B,
        15'h0027, 15'h0060, 15'h4002, 15'h005C, 15'h007A, 15'h0078, 15'h0063, 15'h0076,
        15'h0062, 15'h006E, 15'h006D, 15'h002C, 15'h002E, 15'h002F, 15'h4006, 15'h002A,
        15'h4008, 15'h0020, 15'h4001, 15'h1201, 15'h1202, 15'h1203, 15'h1204, 15'h1205,
        15'h1206, 15'h1207, 15'h1208, 15'h1209, 15'h120A, 15'h300F, 15'h4010, 15'h400C,
        15'h0038, 15'h0039, 15'h002D, 15'h0034, 15'h0035, 15'h0036, 15'h002B, 15'h0031,
        15'h0032, 15'h0033, 15'h0030, 15'h002E, 15'h4012, 15'h4012, 15'h4012, 15'h120B,
        15'h120C
    };

    localparam logic [7:0] AT_TO_XT [0:127] = '{
        8'hff,8'h43,8'h41,8'h3f,8'h3d,8'h3b,8'h3c,8'h58,8'h64,8'h44,8'h42,8'h40,8'h3e,8'h0f,8'h29,8'h59,
        8'h65,8'h38,8'h2a,8'h70,8'h1d,8'h10,8'h02,8'h5a,8'h66,8'h71,8'h2c,8'h1f,8'h1e,8'h11,8'h03,8'h5b,
        8'h67,8'h2e,8'h2d,8'h20,8'h12,8'h05,8'h04,8'h5c,8'h68,8'h39,8'h2f,8'h21,8'h14,8'h13,8'h06,8'h5d,
        8'h69,8'h31,8'h30,8'h23,8'h22,8'h15,8'h07,8'h5e,8'h6a,8'h72,8'h32,8'h24,8'h16,8'h08,8'h09,8'h5f,
        8'h6b,8'h33,8'h25,8'h17,8'h18,8'h0b,8'h0a,8'h60,8'h6c,8'h34,8'h35,8'h26,8'h27,8'h19,8'h0c,8'h61,
        8'h6d,8'h73,8'h28,8'h74,8'h1a,8'h0d,8'h62,8'h6e,8'h3a,8'h36,8'h1c,8'h1b,8'h75,8'h2b,8'h63,8'h76,
        8'h55,8'h56,8'h77,8'h78,8'h79,8'h7a,8'h0e,8'h7b,8'h7c,8'h4f,8'h7d,8'h4b,8'h47,8'h7e,8'h7f,8'h6f,
        8'h52,8'h53,8'h50,8'h4c,8'h4d,8'h48,8'h01,8'h45,8'h57,8'h4e,8'h51,8'h4a,8'h37,8'h49,8'h46,8'h54
    };

    // us layout shift mapping of punctuation and digits
    function automatic logic [14:0] shifted(input logic [14:0] k);
        logic [14:0] r;
        r = k;
        case (k)
            15'h30: r = 15'h29;
            15'h31: r = 15'h21;
            15'h32: r = 15'h40;
            15'h33: r = 15'h23;
            15'h34: r = 15'h24;
            15'h35: r = 15'h25;
            15'h36: r = 15'h5E;
            15'h37: r = 15'h26;
            15'h38: r = 15'h2A;
            15'h39: r = 15'h28;
            15'h2C: r = 15'h3C;
            15'h2E: r = 15'h3E;
            15'h2F: r = 15'h3F;
            15'h3B: r = 15'h3A;
            15'h27: r = 15'h22;
            15'h5B: r = 15'h7B;
            15'h5D: r = 15'h7D;
            15'h60: r = 15'h7E;
            15'h2D: r = 15'h5F;
            15'h3D: r = 15'h2B;
            15'h5C: r = 15'h7C;
            default: r = k;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ps2_scancode_to_key_decoder_unit.sv */
// ps2 keyboard scan byte decoder: set 1 / set 2 bytes to key codes, led commands and reboot requests
// depends on ps2kd_pkg (tables, result type, codes)
// path: a request is registered on acceptance and then decoded into a two-entry result
// queue, from whose head its first result shows on m_; a full queue can hold it back.
// throughput: one scan byte per cycle while the queue has room; a lock key needs both
// queue slots, so right after another two-result request it waits while the queue drains.
// reset: aresetn low at a clock edge clears all key state, flags and queues;
// scan_set returns to 2 and raw_mode to 0. no clearing pass is needed.
module ps2_scancode_to_key_decoder_unit
    import ps2kd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] scan_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [14:0] value, [15] ack_underflow, [16] bat_failed,
                                    // [17] diag_failed, [18] resend_requested, zero pad
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata
);

    logic [1:0] scan_set_reg;
    logic       raw_mode_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    logic       ext_reg, ext_next;
    logic       brk_reg, brk_next;
    logic       shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic       alt_reg, alt_next;
    logic [2:0] led_reg, led_next;
    logic [7:0] acks_reg, acks_next;
    logic [3:0] status_reg, status_next;

    res_t       q_reg [0:1];
    res_t       q_next [0:1];
    logic [1:0] cnt_reg, cnt_next;

    logic [7:0]  code;
    logic [14:0] key;
    logic [1:0]  n_res;
    res_t        r0, r1;
    logic [2:0]  toggle;
    logic        pop, fire;
    logic [1:0]  free_slots, cnt_p;
    logic        is_mod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_set_reg <= SCAN_SET_RESET;
            raw_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SCAN_SET: scan_set_reg <= cfg_wdata;
                CFG_RAW_MODE: raw_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // translation path: set 1 drops the break bit, others send bytes < 80h via the at rom
    always_comb begin
        if (scan_set_reg == SCAN_SET_XT) begin
            code = {1'b0, in_byte_reg[6:0]};
        end else if (in_byte_reg[7]) begin
            code = XT_NONE;
        end else begin
            code = AT_TO_XT[in_byte_reg[6:0]];
        end
        key = (code <= XT_MAX) ? XT_KEYS[code[6:0]] : KC_UNKNOWN;
    end

    always_comb begin
        ext_next    = ext_reg;
        brk_next    = brk_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        led_next    = led_reg;
        acks_next   = acks_reg;
        status_next = status_reg;
        n_res       = 2'd0;
        toggle      = 3'b000;
        r0          = '{kind: KIND_KEY, value: key, last: 1'b1, flags: status_reg};
        r1          = '{kind: KIND_CMD, value: {12'd0, led_reg ^ toggle}, last: 1'b1,
                        flags: status_reg};
        is_mod      = (key == KC_LCTRL) || (key == KC_RCTRL) || (key == KC_LSHIFT)
                   || (key == KC_RSHIFT) || (key == KC_LALT) || (key == KC_RALT);
        case (in_byte_reg)
            BYTE_EXT0, BYTE_EXT1: ext_next = 1'b1;
            BYTE_ACK: begin
                if (acks_reg == 8'd0) begin
                    status_next[0] = 1'b1;
                end else begin
                    acks_next = acks_reg - 8'd1;
                end
            end
            BYTE_BAT:    status_next[1] = 1'b1;
            BYTE_DIAG:   status_next[2] = 1'b1;
            BYTE_RESEND: status_next[3] = 1'b1;
            default: begin
                if (scan_set_reg != SCAN_SET_XT && in_byte_reg == BYTE_BREAK) begin
                    brk_next = 1'b1;
                end else begin
                    // set 1 break bit is noted even in raw mode
                    if (scan_set_reg == SCAN_SET_XT && in_byte_reg[7]) begin
                        brk_next = 1'b1;
                    end
                    if (raw_mode_reg) begin
                        n_res = 2'd1;
                    end else begin
                        ext_next = 1'b0;
                        if (brk_next) begin
                            brk_next = 1'b0;
                            if (key == KC_LCTRL || key == KC_RCTRL) begin
                                ctrl_next = 1'b0;
                            end else if (key == KC_LSHIFT || key == KC_RSHIFT) begin
                                shift_next = 1'b0;
                            end else if (key == KC_LALT || key == KC_RALT) begin
                                alt_next = 1'b0;
                            end
                        end else begin
                            if (key == KC_LCTRL || key == KC_RCTRL) begin
                                ctrl_next = 1'b1;
                            end else if (key == KC_LSHIFT || key == KC_RSHIFT) begin
                                shift_next = 1'b1;
                            end else if (key == KC_LALT || key == KC_RALT) begin
                                alt_next = 1'b1;
                            end else if (key == KC_SCROLL) begin
                                toggle = LED_SCROLL;
                            end else if (key == KC_NUMLOCK) begin
                                toggle = LED_NUM;
                            end else if (key == KC_CAPS) begin
                                toggle = LED_CAPS;
                            end
                            if (toggle != 3'b000) begin
                                led_next  = led_reg ^ toggle;
                                acks_next = (acks_reg >= ACK_SAT) ? 8'hFF : acks_reg + 8'd2;
                                n_res     = 2'd2;
                                r0 = '{kind: KIND_CMD, value: {7'd0, CMD_SET_LEDS},
                                       last: 1'b0, flags: status_reg};
                                r1 = '{kind: KIND_CMD, value: {12'd0, led_reg ^ toggle},
                                       last: 1'b1, flags: status_reg};
                            end else if (!is_mod) begin
                                n_res = 2'd1;
                                if ((shift_reg || led_reg[2]) && key >= KC_LOWER_A
                                        && key <= KC_LOWER_Z) begin
                                    r0.value = key - CASE_GAP;
                                end else if (shift_reg) begin
                                    r0.value = shifted(key);
                                end else if (ctrl_reg && alt_reg && ext_reg
                                        && key == KC_DOT) begin
                                    r0.kind  = KIND_REBOOT;
                                    r0.value = 15'd0;
                                end
                            end
                        end
                    end
                end
            end
        endcase
    end

    // output queue: pop at the head, push behind whatever remains
    assign pop        = (cnt_reg != 2'd0) && m_tready;
    assign free_slots = 2'd2 - cnt_reg + {1'b0, pop};
    assign fire       = in_valid_reg && (n_res <= free_slots);
    assign cnt_p      = cnt_reg - {1'b0, pop};
    assign s_tready   = !in_valid_reg || fire;

    always_comb begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_p;
        if (fire) begin
            cnt_next = cnt_p + n_res;
            case (n_res)
                2'd1: begin
                    if (cnt_p == 2'd0) begin
                        q_next[0] = r0;
                    end else begin
                        q_next[1] = r0;
                    end
                end
                2'd2: begin
                    q_next[0] = r0;
                    q_next[1] = r1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            ext_reg      <= 1'b0;
            brk_reg      <= 1'b0;
            shift_reg    <= 1'b0;
            ctrl_reg     <= 1'b0;
            alt_reg      <= 1'b0;
            led_reg      <= 3'b000;
            acks_reg     <= 8'd0;
            status_reg   <= 4'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            cnt_reg <= cnt_next;
            if (fire) begin
                ext_reg    <= ext_next;
                brk_reg    <= brk_next;
                shift_reg  <= shift_next;
                ctrl_reg   <= ctrl_next;
                alt_reg    <= alt_next;
                led_reg    <= led_next;
                acks_reg   <= acks_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;
    assign m_tdata  = {5'd0, q_reg[0].flags, q_reg[0].value};

endmodule

/* rtl/ps2kd_checker.sv */
// port-level checker for the ps2 scan code decoder, bound to the top level
// depends on ps2kd_pkg and ps2_scancode_to_key_decoder_unit_defines.svh
`include "ps2_scancode_to_key_decoder_unit_defines.svh"

module ps2kd_checker
    import ps2kd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a held result must not change under back-pressure
    `PS2KD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // the led command byte is always followed by the mask in the same request
    `PS2KD_ASSERT_NOW(a_cmd_first, aclk, aresetn,
        m_tvalid && m_tuser == KIND_CMD && m_tdata[14:0] == {7'd0, CMD_SET_LEDS},
        !m_tlast)

    // the closing command result carries only a three-bit led mask
    `PS2KD_ASSERT_NOW(a_cmd_mask, aclk, aresetn,
        m_tvalid && m_tuser == KIND_CMD && m_tlast, m_tdata[14:3] == 12'd0)

    // a reboot stands alone with a zero value
    `PS2KD_ASSERT_NOW(a_reboot, aclk, aresetn, m_tvalid && m_tuser == KIND_REBOOT,
        m_tlast && m_tdata[14:0] == 15'd0)

endmodule

bind ps2_scancode_to_key_decoder_unit ps2kd_checker u_ps2kd_checker (.*);

/* test/tb_ps2_scancode_to_key_decoder_unit.sv */
`timescale 1ns / 100ps
// self-checking bench for the ps2 scan byte decoder: scan bytes in, key codes, led
// commands and reboot requests out, checked against a behavioural decoder held here
// depends on ps2kd_pkg and rtl/ps2_scancode_to_key_decoder_unit.sv
module tb_ps2_scancode_to_key_decoder_unit
    import ps2kd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 40;
    localparam int REPORT_MAX   = 10;

    // keyboard bytes used to build well-formed sequences
    localparam int MOD_LSHIFT = 0;
    localparam int MOD_RSHIFT = 1;
    localparam int MOD_CTRL   = 2;
    localparam int MOD_ALT    = 3;
    localparam int LOCK_CAPS   = 0;
    localparam int LOCK_NUM    = 1;
    localparam int LOCK_SCROLL = 2;
    localparam logic [7:0] SET2_MOD  [0:3] = '{8'h12, 8'h59, 8'h14, 8'h11};
    localparam logic [7:0] SET1_MOD  [0:3] = '{8'h2A, 8'h36, 8'h1D, 8'h38};
    localparam logic [7:0] SET2_LOCK [0:2] = '{8'h58, 8'h77, 8'h7E};
    localparam logic [7:0] SET1_LOCK [0:2] = '{8'h3A, 8'h45, 8'h46};
    localparam logic [7:0] SET2_KP_DOT = 8'h71;
    localparam logic [7:0] SET1_KP_DOT = 8'h53;
    localparam logic [7:0] SET2_KEY_A  = 8'h1C;
    localparam logic [7:0] SET2_KEY_3  = 8'h26;
    localparam logic [7:0] EDGE_BYTES [0:3] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

    // xt code to key code
    localparam logic [14:0] XT_KEY_ROM [0:88] = '{
        15'h4012, 15'h1001, 15'h0031, 15'h0032, 15'h0033, 15'h0034, 15'h0035, 15'h0036,
        15'h0037, 15'h0038, 15'h0039, 15'h0030, 15'h002D, 15'h003D, 15'h0008, 15'h4000,
        15'h0071, 15'h0077, 15'h0065, 15'h0072, 15'h0074, 15'h0079, 15'h0075, 15'h0069,
        15'h006F, 15'h0070, 15'h005B, 15'h005D, 15'h000D, 15'h4003, 15'h0061, 15'h0073,
        15'h0064, 15'h0066, 15'h0067, 15'h0068, 15'h006A, 15'h006B, 15'h006C, 15'h003B,
        15'h0027, 15'h0060, 15'h4002, 15'h005C, 15'h007A, 15'h0078, 15'h0063, 15'h0076,
        15'h0062, 15'h006E, 15'h006D, 15'h002C, 15'h002E, 15'h002F, 15'h4006, 15'h002A,
        15'h4008, 15'h0020, 15'h4001, 15'h1201, 15'h1202, 15'h1203, 15'h1204, 15'h1205,
        15'h1206, 15'h1207, 15'h1208, 15'h1209, 15'h120A, 15'h300F, 15'h4010, 15'h400C,
        15'h0038, 15'h0039, 15'h002D, 15'h0034, 15'h0035, 15'h0036, 15'h002B, 15'h0031,
        15'h0032, 15'h0033, 15'h0030, 15'h002E, 15'h4012, 15'h4012, 15'h4012, 15'h120B,
        15'h120C
    };

    // set 2 byte to xt code
    localparam logic [7:0] AT_XT_ROM [0:127] = '{
        8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58,
        8'h64, 8'h44, 8'h42, 8'h40, 8'h3e, 8'h0f, 8'h29, 8'h59,
        8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
        8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b,
        8'h67, 8'h2e, 8'h2d, 8'h20, 8'h12, 8'h05, 8'h04, 8'h5c,
        8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
        8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e,
        8'h6a, 8'h72, 8'h32, 8'h24, 8'h16, 8'h08, 8'h09, 8'h5f,
        8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
        8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61,
        8'h6d, 8'h73, 8'h28, 8'h74, 8'h1a, 8'h0d, 8'h62, 8'h6e,
        8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
        8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b,
        8'h7c, 8'h4f, 8'h7d, 8'h4b, 8'h47, 8'h7e, 8'h7f, 8'h6f,
        8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
        8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] value;
        logic        last;
        logic [3:0]  status;
    } key_event_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;

    logic [7:0]  scan_bytes [$];
    key_event_t  key_events [$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // decoder state as the keyboard driver sees it
    logic [1:0]  scan_set_reg = SCAN_SET_RESET;
    logic        raw_reg      = 1'b0;
    logic        ext_prefix   = 1'b0;
    logic        break_next   = 1'b0;
    logic        shift_held   = 1'b0;
    logic        ctrl_held    = 1'b0;
    logic        alt_held     = 1'b0;
    logic [2:0]  lock_leds    = 3'd0;
    logic [7:0]  acks_owed    = 8'd0;
    logic [3:0]  sticky_status = 4'd0;

    ps2_scancode_to_key_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // us layout, shifted digits and punctuation
    function automatic logic [14:0] us_shift(input logic [14:0] k);
        logic [14:0] r;
        r = k;
        case (k)
            "1": r = "!";
            "2": r = "@";
            "3": r = "#";
            "4": r = "$";
            "5": r = "%";
            "6": r = "^";
            "7": r = "&";
            "8": r = "*";
            "9": r = "(";
            "0": r = ")";
            "-": r = "_";
            "=": r = "+";
            "[": r = "{";
            "]": r = "}";
            ";": r = ":";
            "'": r = "\"";
            "\\": r = "|";
            ",": r = "<";
            ".": r = ">";
            "/": r = "?";
            15'h60: r = "~";    // backtick
            default: r = k;
        endcase
        return r;
    endfunction

    function automatic key_event_t key_event(input logic [1:0] kind, input logic [14:0] value);
        key_event_t e;
        e.kind   = kind;
        e.value  = value;
        e.last   = 1'b0;
        e.status = sticky_status;
        return e;
    endfunction

    // works out the results of one accepted request and queues them
    task automatic decode_scan_byte(input logic [7:0] b);
        logic [7:0]  xt;
        logic [14:0] key;
        logic [2:0]  toggle;
        logic        consumed;
        key_event_t  res [0:1];
        int          n;
        int          i;
        n = 0;
        xt = XT_NONE;
        toggle = 3'd0;
        consumed = 1'b1;
        case (b)
            BYTE_EXT0, BYTE_EXT1: ext_prefix = 1'b1;
            BYTE_ACK: begin
                if (acks_owed == 8'd0) sticky_status[0] = 1'b1;
                else acks_owed = acks_owed - 8'd1;
            end
            BYTE_BAT:    sticky_status[1] = 1'b1;
            BYTE_DIAG:   sticky_status[2] = 1'b1;
            BYTE_RESEND: sticky_status[3] = 1'b1;
            default:     consumed = 1'b0;
        endcase
        if (!consumed) begin
            if (scan_set_reg == SCAN_SET_XT) begin
                if (b[7]) break_next = 1'b1;
                xt = {1'b0, b[6:0]};
            end else if (b == BYTE_BREAK) begin
                break_next = 1'b1;
                consumed = 1'b1;
            end else begin
                xt = b[7] ? XT_NONE : AT_XT_ROM[b[6:0]];
            end
        end
        if (!consumed) begin
            key = (xt <= XT_MAX) ? XT_KEY_ROM[xt] : KC_UNKNOWN;
            if (raw_reg) begin
                res[0] = key_event(KIND_KEY, key);
                n = 1;
            end else begin
                if (break_next) begin
                    break_next = 1'b0;
                    if (key == KC_LCTRL || key == KC_RCTRL) ctrl_held = 1'b0;
                    else if (key == KC_LSHIFT || key == KC_RSHIFT) shift_held = 1'b0;
                    else if (key == KC_LALT || key == KC_RALT) alt_held = 1'b0;
                end else begin
                    if (key == KC_LCTRL || key == KC_RCTRL) ctrl_held = 1'b1;
                    else if (key == KC_LSHIFT || key == KC_RSHIFT) shift_held = 1'b1;
                    else if (key == KC_LALT || key == KC_RALT) alt_held = 1'b1;
                    else if (key == KC_SCROLL) toggle = LED_SCROLL;
                    else if (key == KC_NUMLOCK) toggle = LED_NUM;
                    else if (key == KC_CAPS) toggle = LED_CAPS;
                    else begin
                        n = 1;
                        if ((shift_held || lock_leds[2]) && key >= KC_LOWER_A
                                && key <= KC_LOWER_Z) begin
                            res[0] = key_event(KIND_KEY, key - CASE_GAP);
                        end else if (shift_held) begin
                            res[0] = key_event(KIND_KEY, us_shift(key));
                        end else if (ctrl_held && alt_held && ext_prefix && key == KC_DOT) begin
                            res[0] = key_event(KIND_REBOOT, 15'd0);
                        end else begin
                            res[0] = key_event(KIND_KEY, key);
                        end
                    end
                    if (toggle != 3'd0) begin
                        lock_leds = lock_leds ^ toggle;
                        acks_owed = (acks_owed >= ACK_SAT) ? 8'd255 : acks_owed + 8'd2;
                        res[0] = key_event(KIND_CMD, {7'd0, CMD_SET_LEDS});
                        res[1] = key_event(KIND_CMD, {12'd0, lock_leds});
                        n = 2;
                    end
                end
                ext_prefix = 1'b0;
            end
        end
        for (i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            key_events.push_back(res[i]);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_scan_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (scan_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= scan_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        key_event_t  want;
        logic [23:0] want_data;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (key_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result kind %0d data %h last %b",
                                 $realtime, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = key_events.pop_front();
                    want_data = {5'd0, want.status, want.value};
                    if (m_tuser !== want.kind || m_tdata !== want_data
                            || m_tlast !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: got kind %0d data %h last %b, want kind %0d data %h last %b",
                                     $realtime, m_tuser, m_tdata, m_tlast,
                                     want.kind, want_data, want.last);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_register(input cfg_index_t idx, input logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SCAN_SET) scan_set_reg = val;
        else raw_reg = val[0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (scan_bytes.size() != 0 || s_tvalid || key_events.size() != 0)
            @(posedge aclk);
        // a status byte may still sit in the pipe with nothing expected from it
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one make or break of a key in either set, optionally with the extended prefix
    task automatic queue_key(input logic [7:0] at_code, input logic [7:0] xt_code,
                             input bit xt_set, input bit ext, input bit brk);
        if (ext) scan_bytes.push_back(BYTE_EXT0);
        if (xt_set) begin
            scan_bytes.push_back(brk ? {1'b1, xt_code[6:0]} : xt_code);
        end else begin
            if (brk) scan_bytes.push_back(BYTE_BREAK);
            scan_bytes.push_back(at_code);
        end
    endtask

    task automatic queue_keystroke(input bit xt_set);
        int         sel;
        int         idx;
        bit         ext;
        logic [7:0] at_code;
        logic [7:0] xt_code;
        sel = $urandom_range(99);
        ext = ($urandom_range(3) == 0);
        if (sel < 10) begin
            scan_bytes.push_back(8'($urandom_range(255)));
        end else if (sel < 16) begin
            scan_bytes.push_back(BYTE_ACK);
        end else if (sel < 21) begin
            idx = $urandom_range(2);
            queue_key(SET2_LOCK[idx], SET1_LOCK[idx], xt_set, 1'b0, 1'b0);
            queue_key(SET2_LOCK[idx], SET1_LOCK[idx], xt_set, 1'b0, 1'b1);
        end else if (sel < 26) begin
            // ctrl-alt-del attempt
            queue_key(SET2_MOD[MOD_CTRL], SET1_MOD[MOD_CTRL], xt_set, 1'b0, 1'b0);
            queue_key(SET2_MOD[MOD_ALT], SET1_MOD[MOD_ALT], xt_set, ext, 1'b0);
            queue_key(SET2_KP_DOT, SET1_KP_DOT, xt_set, 1'b1, 1'b0);
            queue_key(SET2_MOD[MOD_CTRL], SET1_MOD[MOD_CTRL], xt_set, 1'b0, 1'b1);
            queue_key(SET2_MOD[MOD_ALT], SET1_MOD[MOD_ALT], xt_set, ext, 1'b1);
        end else if (sel < 45) begin
            idx = $urandom_range(3);
            queue_key(SET2_MOD[idx], SET1_MOD[idx], xt_set, ext, $urandom_range(1));
        end else begin
            at_code = 8'($urandom_range(127));
            xt_code = ($urandom_range(7) == 0) ? 8'($urandom_range(127))
                                               : 8'($urandom_range(88));
            queue_key(at_code, xt_code, xt_set, ext, 1'b0);
            if ($urandom_range(1)) queue_key(at_code, xt_code, xt_set, ext, 1'b1);
        end
    endtask

    task automatic run_phase(input logic [1:0] set, input logic raw,
                             input int send_pct, input int recv_pct);
        write_register(CFG_SCAN_SET, set);
        write_register(CFG_RAW_MODE, {1'b0, raw});
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (scan_bytes.size() < PHASE_ITEMS) queue_keystroke(set == SCAN_SET_XT);
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: set 2, cooked mode
        queue_key(SET2_KEY_A, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_MOD[MOD_LSHIFT], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_KEY_A, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_KEY_3, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_MOD[MOD_LSHIFT], 8'd0, 1'b0, 1'b0, 1'b1);
        queue_key(SET2_LOCK[LOCK_CAPS], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_KEY_A, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_LOCK[LOCK_NUM], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_LOCK[LOCK_SCROLL], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_MOD[MOD_CTRL], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_MOD[MOD_ALT], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_KP_DOT, 8'd0, 1'b0, 1'b1, 1'b0);
        queue_key(SET2_MOD[MOD_CTRL], 8'd0, 1'b0, 1'b0, 1'b1);
        queue_key(SET2_MOD[MOD_ALT], 8'd0, 1'b0, 1'b0, 1'b1);
        scan_bytes.push_back(BYTE_ACK);
        scan_bytes.push_back(BYTE_BAT);
        scan_bytes.push_back(BYTE_DIAG);
        scan_bytes.push_back(BYTE_RESEND);
        scan_bytes.push_back(BYTE_EXT1);
        foreach (EDGE_BYTES[i]) scan_bytes.push_back(EDGE_BYTES[i]);
        queue_key(SET2_MOD[MOD_RSHIFT], 8'd0, 1'b0, 1'b0, 1'b0);
        queue_key(SET2_MOD[MOD_RSHIFT], 8'd0, 1'b0, 1'b0, 1'b1);
        wait_idle();

        // drive the ack count into saturation, drain it, then one ack too many
        repeat (130) queue_key(SET2_LOCK[LOCK_SCROLL], 8'd0, 1'b0, 1'b0, 1'b0);
        repeat (256) scan_bytes.push_back(BYTE_ACK);
        queue_key(SET2_KEY_A, 8'd0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        run_phase(2'd2, 1'b0, 0, 0);
        run_phase(2'd2, 1'b0, 88, 0);
        run_phase(2'd1, 1'b0, 0, 88);
        run_phase(2'd3, 1'b0, 31, 31);
        run_phase(2'd1, 1'b1, 0, 0);
        run_phase(2'd0, 1'b0, 88, 0);
        run_phase(2'd2, 1'b1, 0, 88);
        run_phase(2'd3, 1'b1, 31, 31);
        run_phase(2'd1, 1'b0, 31, 31);

        if (mismatch_count == 0 && key_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* ps2_scancode_to_key_decoder_unit.f */
+incdir+rtl
rtl/ps2kd_pkg.sv
rtl/ps2_scancode_to_key_decoder_unit.sv
rtl/ps2kd_checker.sv
test/tb_ps2_scancode_to_key_decoder_unit.sv
